/* rtl/core/cdsc_pkg.sv */
// Package with the shared types, constants and register map of the segment cutter.
package cdsc_pkg;

	localparam logic [31:0] HASH_BASIS = 32'h8422_2325;
	localparam logic [31:0] HASH_PRIME = 32'h0000_01b3;
	localparam logic [31:0] MIX_A      = 32'h85eb_ca6b;
	localparam logic [31:0] MIX_B      = 32'hc2b2_ae35;
	localparam logic [31:0] NARROW_LIMIT = 32'h0040_0000;

	localparam int unsigned ADDR_W = 4;

	localparam logic [15:0] MIN_ELEMENTS_RST   = 16'd64;
	localparam logic [31:0] MIN_SIZE_BYTES_RST = 32'd65536;
	localparam logic [15:0] MAX_ELEMENTS_RST   = 16'd16384;
	localparam logic [31:0] MAX_SIZE_BYTES_RST = 32'd16777216;

	typedef enum logic [1:0] {
		REG_MIN_ELEMENTS   = 2'd0,
		REG_MIN_SIZE_BYTES = 2'd1,
		REG_MAX_ELEMENTS   = 2'd2,
		REG_MAX_SIZE_BYTES = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [15:0] min_elements;
		logic [31:0] min_size_bytes;
		logic [15:0] max_elements;
		logic [31:0] max_size_bytes;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_MIX0,
		S_MIX1,
		S_MIX2,
		S_DECIDE
	} state_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

/* rtl/core/cdsc_item_if.sv */
// Input channel interface carrying one encoded byte per transfer.
interface cdsc_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       key_byte;
	logic       element_end;

	modport source (output valid, output data_byte, output key_byte, output element_end,
		input ready);
	modport sink (input valid, input data_byte, input key_byte, input element_end,
		output ready);
endinterface

/* rtl/core/cdsc_result_if.sv */
// Output channel interface carrying one segment decision per transfer.
interface cdsc_result_if;
	logic valid;
	logic ready;
	logic starts_segment;
	logic forced_by_limit;

	modport source (output valid, output starts_segment, output forced_by_limit, input ready);
	modport sink (input valid, input starts_segment, input forced_by_limit, output ready);
endinterface

/* rtl/core/cdsc_regs.sv */
// APB-style configuration register file of the segment cutter.
module cdsc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdsc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output cdsc_pkg::cfg_regs_t           regs
);
	cdsc_pkg::cfg_regs_t regs_q;
	cdsc_pkg::reg_index_t idx;

	assign idx    = cdsc_pkg::reg_index_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign regs   = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.min_elements   <= cdsc_pkg::MIN_ELEMENTS_RST;
			regs_q.min_size_bytes <= cdsc_pkg::MIN_SIZE_BYTES_RST;
			regs_q.max_elements   <= cdsc_pkg::MAX_ELEMENTS_RST;
			regs_q.max_size_bytes <= cdsc_pkg::MAX_SIZE_BYTES_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				cdsc_pkg::REG_MIN_ELEMENTS:   regs_q.min_elements   <= pwdata[15:0];
				cdsc_pkg::REG_MIN_SIZE_BYTES: regs_q.min_size_bytes <= pwdata;
				cdsc_pkg::REG_MAX_ELEMENTS:   regs_q.max_elements   <= pwdata[15:0];
				cdsc_pkg::REG_MAX_SIZE_BYTES: regs_q.max_size_bytes <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			cdsc_pkg::REG_MIN_ELEMENTS:   prdata = {16'b0, regs_q.min_elements};
			cdsc_pkg::REG_MIN_SIZE_BYTES: prdata = regs_q.min_size_bytes;
			cdsc_pkg::REG_MAX_ELEMENTS:   prdata = {16'b0, regs_q.max_elements};
			cdsc_pkg::REG_MAX_SIZE_BYTES: prdata = regs_q.max_size_bytes;
			default:                      prdata = 32'b0;
		endcase
	end
endmodule

/* rtl/core/cdsc_mul.sv */
// Shared registered multiplier used for hashing, mixing and the threshold compare.
module cdsc_mul (
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [31:0] b,
	output logic [64:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= {32'b0, a} * {33'b0, b};
	end
endmodule

/* rtl/core/content_defined_segment_cutter.sv */
// Top level of the content-defined segment cutter with its sequencer.
//
//   channel  direction  handshake        payload
//   item     in         valid / ready    data_byte, key_byte, element_end
//   result   out        valid / ready    starts_segment, forced_by_limit
//   config   in         APB write/read   min/max element count and byte total
//
// A plain byte is taken in S_IDLE; a key byte also passes S_HASH to fold in its product from the shared multiplier.
// An element's last byte then runs S_MIX0, S_MIX1, S_MIX2 and S_DECIDE: two mixing products, one threshold
// product (hash + 1) * count compared against bytes * 4096, and the decision.
// Reset clears the segment state and loads the register defaults.
// The decision waits while an earlier result has not yet been transferred.
module content_defined_segment_cutter (
	input  logic                        clk,
	input  logic                        arst_n,
	cdsc_item_if.sink                   item,
	cdsc_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cdsc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	cdsc_pkg::cfg_regs_t regs;
	cdsc_pkg::state_t    state_q, state_d;

	logic [32:0] mul_a;
	logic [31:0] mul_b;
	logic [64:0] prod_q;

	logic [31:0] hash_q, len_q, mix_q, bytes_q;
	logic [15:0] count_q;
	logic        end_q;
	logic        out_valid_q, starts_q, forced_q;
	logic        decide_go;

	logic [31:0] p_lo, p13, fin;
	logic        cnt_nz, forced, below_min, hash_cut, cut;

	cdsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.regs    (regs)
	);

	cdsc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign p_lo = prod_q[31:0];
	assign p13  = p_lo ^ (p_lo >> 13);
	assign fin  = p_lo ^ (p_lo >> 16);

	assign cnt_nz    = count_q != 16'd0;
	assign forced    = cnt_nz && (count_q >= regs.max_elements ||
		bytes_q >= regs.max_size_bytes);
	assign below_min = count_q < regs.min_elements && bytes_q < regs.min_size_bytes;
	assign hash_cut  = mix_q < cdsc_pkg::NARROW_LIMIT ||
		prod_q[48:0] <= {5'b0, bytes_q, 12'b0};
	assign cut       = forced || (cnt_nz && !below_min && hash_cut);

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		decide_go  = 1'b0;
		mul_a      = 33'b0;
		mul_b      = 32'b0;
		case (state_q)
			cdsc_pkg::S_IDLE: begin
				item.ready = 1'b1;
				mul_a      = {1'b0, hash_q ^ {24'b0, item.data_byte}};
				mul_b      = cdsc_pkg::HASH_PRIME;
				if (item.valid) begin
					if (item.key_byte) begin
						state_d = cdsc_pkg::S_HASH;
					end else if (item.element_end) begin
						state_d = cdsc_pkg::S_MIX0;
					end
				end
			end
			cdsc_pkg::S_HASH: begin
				state_d = end_q ? cdsc_pkg::S_MIX0 : cdsc_pkg::S_IDLE;
			end
			cdsc_pkg::S_MIX0: begin
				mul_a   = {1'b0, hash_q ^ (hash_q >> 16)};
				mul_b   = cdsc_pkg::MIX_A;
				state_d = cdsc_pkg::S_MIX1;
			end
			cdsc_pkg::S_MIX1: begin
				mul_a   = {1'b0, p13};
				mul_b   = cdsc_pkg::MIX_B;
				state_d = cdsc_pkg::S_MIX2;
			end
			cdsc_pkg::S_MIX2: begin
				mul_a   = {1'b0, fin} + 33'd1;
				mul_b   = {16'b0, count_q};
				state_d = cdsc_pkg::S_DECIDE;
			end
			cdsc_pkg::S_DECIDE: begin
				mul_a = {1'b0, mix_q} + 33'd1;
				mul_b = {16'b0, count_q};
				if (!(out_valid_q && !result.ready)) begin
					decide_go = 1'b1;
					state_d   = cdsc_pkg::S_IDLE;
				end
			end
			default: state_d = cdsc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdsc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= cdsc_pkg::HASH_BASIS;
			len_q       <= 32'b0;
			count_q     <= 16'b0;
			bytes_q     <= 32'b0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				end_q <= item.element_end;
				len_q <= cdsc_pkg::sat_add32(len_q, 32'd1);
			end
			if (state_q == cdsc_pkg::S_HASH) begin
				hash_q <= p_lo;
			end
			if (result.valid && result.ready && !decide_go) begin
				out_valid_q <= 1'b0;
			end
			if (decide_go) begin
				if (cut) begin
					count_q <= 16'd1;
					bytes_q <= len_q;
				end else begin
					if (count_q != 16'hFFFF) begin
						count_q <= count_q + 16'd1;
					end
					bytes_q <= cdsc_pkg::sat_add32(bytes_q, len_q);
				end
				hash_q      <= cdsc_pkg::HASH_BASIS;
				len_q       <= 32'b0;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cdsc_pkg::S_MIX2) begin
			mix_q <= fin;
		end
		if (decide_go) begin
			starts_q <= cut;
			forced_q <= forced;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.starts_segment  = starts_q;
	assign result.forced_by_limit = forced_q;

	a_rise_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == cdsc_pkg::S_DECIDE))
		else $error("result appeared without a decision");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> count_q != 16'd0)
		else $error("segment count is zero with a result pending");

	a_forced_is_cut: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && forced_q) |-> starts_q)
		else $error("forced cut without segment start");

	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		decide_go |=> (hash_q == cdsc_pkg::HASH_BASIS && len_q == 32'b0))
		else $error("element state not reloaded after decision");
endmodule

/* sim/tb.sv */
// Testbench for the content-defined segment cutter: a cut predictor checks every segment decision.
`timescale 1ns / 100ps

typedef struct packed {
	logic starts;
	logic forced;
} cut_decision_t;

class cut_tracker;
	localparam logic [31:0] FNV_SEED  = 32'h8422_2325;
	localparam logic [31:0] FNV_MULT  = 32'h0000_01b3;
	localparam logic [31:0] FMIX_C1   = 32'h85eb_ca6b;
	localparam logic [31:0] FMIX_C2   = 32'hc2b2_ae35;
	localparam logic [63:0] CUT_FLOOR = 64'h0000_0000_0040_0000;

	logic [15:0] min_count;
	logic [31:0] min_bytes;
	logic [15:0] max_count;
	logic [31:0] max_bytes;
	logic [31:0] running_hash;
	logic [31:0] elem_len;
	logic [15:0] seg_count;
	logic [31:0] seg_bytes;
	cut_decision_t pending_cuts[$];
	int mismatches;
	int decisions_seen;

	function new();
		min_count = 16'd64;
		min_bytes = 32'd65536;
		max_count = 16'd16384;
		max_bytes = 32'd16777216;
		running_hash = FNV_SEED;
		elem_len = '0;
		seg_count = '0;
		seg_bytes = '0;
		mismatches = 0;
		decisions_seen = 0;
	endfunction

	static function logic [31:0] fold_byte(logic [31:0] h, logic [7:0] d);
		return (h ^ {24'b0, d}) * FNV_MULT;
	endfunction

	static function logic [31:0] avalanche(logic [31:0] h);
		h = h ^ (h >> 16);
		h = h * FMIX_C1;
		h = h ^ (h >> 13);
		h = h * FMIX_C2;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function void set_register(cdsc_pkg::reg_index_t idx, logic [31:0] v);
		case (idx)
			cdsc_pkg::REG_MIN_ELEMENTS: min_count = v[15:0];
			cdsc_pkg::REG_MIN_SIZE_BYTES: min_bytes = v;
			cdsc_pkg::REG_MAX_ELEMENTS: max_count = v[15:0];
			cdsc_pkg::REG_MAX_SIZE_BYTES: max_bytes = v;
			default: ;
		endcase
	endfunction

	function void take_byte(logic [7:0] d, logic k, logic last);
		logic [63:0] limit;
		logic [32:0] sum;
		cut_decision_t dec;
		if (k)
			running_hash = fold_byte(running_hash, d);
		if (elem_len != 32'hFFFF_FFFF)
			elem_len = elem_len + 32'd1;
		if (!last)
			return;
		dec = '0;
		if (seg_count != 16'd0) begin
			if (seg_count >= max_count || seg_bytes >= max_bytes) begin
				dec.starts = 1'b1;
				dec.forced = 1'b1;
			end else if (!(seg_count < min_count && seg_bytes < min_bytes)) begin
				limit = ({32'b0, seg_bytes} * 64'd4096) / {48'b0, seg_count};
				if (limit < CUT_FLOOR)
					limit = CUT_FLOOR;
				dec.starts = {32'b0, avalanche(running_hash)} < limit;
			end
		end
		if (dec.starts) begin
			seg_count = 16'd1;
			seg_bytes = elem_len;
		end else begin
			if (seg_count != 16'hFFFF)
				seg_count = seg_count + 16'd1;
			sum = {1'b0, seg_bytes} + {1'b0, elem_len};
			seg_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end
		running_hash = FNV_SEED;
		elem_len = '0;
		pending_cuts.push_back(dec);
	endfunction

	function void match_decision(logic starts, logic forced);
		cut_decision_t want;
		decisions_seen++;
		if (pending_cuts.size() == 0) begin
			$display("%0t: decision with none expected: starts_segment=%0b forced_by_limit=%0b",
				$time, starts, forced);
			mismatches++;
			return;
		end
		want = pending_cuts.pop_front();
		if (starts !== want.starts) begin
			$display("%0t: starts_segment expected %0b, got %0b", $time, want.starts, starts);
			mismatches++;
		end
		if (forced !== want.forced) begin
			$display("%0t: forced_by_limit expected %0b, got %0b", $time, want.forced, forced);
			mismatches++;
		end
	endfunction

	function int outstanding();
		return pending_cuts.size();
	endfunction
endclass

module tb;
	typedef enum {KEYS_RANDOM, KEYS_NONE, KEYS_ALL, KEYS_LUCKY, KEYS_WIDE} key_style_t;

	localparam int LONG_LEN = 1100;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [cdsc_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	cdsc_item_if item_ch ();
	cdsc_result_if result_ch ();

	cut_tracker tracker = new();

	logic [7:0] elem_data[$];
	bit elem_key[$];
	logic [15:0] lucky_keys[$];
	logic [15:0] wide_keys[$];
	bit tx_calm;
	bit rx_calm;
	int items_sent;

	content_defined_segment_cutter dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	task automatic reg_write(input cdsc_pkg::reg_index_t idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_register(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic load_limits(input logic [31:0] min_c, input logic [31:0] min_b,
		input logic [31:0] max_c, input logic [31:0] max_b);
		reg_write(cdsc_pkg::REG_MIN_ELEMENTS, min_c);
		reg_write(cdsc_pkg::REG_MIN_SIZE_BYTES, min_b);
		reg_write(cdsc_pkg::REG_MAX_ELEMENTS, max_c);
		reg_write(cdsc_pkg::REG_MAX_SIZE_BYTES, max_b);
	endtask

	task automatic send_byte(input logic [7:0] d, input logic k, input logic last);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_ch.valid = 1'b1;
		item_ch.data_byte = d;
		item_ch.key_byte = k;
		item_ch.element_end = last;
		do @(posedge clk); while (!item_ch.ready);
		tracker.take_byte(d, k, last);
		items_sent++;
	endtask

	task automatic put_byte(input logic [7:0] d, input bit k);
		elem_data.push_back(d);
		elem_key.push_back(k);
	endtask

	task automatic push_element();
		for (int i = 0; i < elem_data.size(); i++)
			send_byte(elem_data[i], elem_key[i], i == elem_data.size() - 1);
		elem_data.delete();
		elem_key.delete();
	endtask

	task automatic build_element(input int len, input key_style_t style);
		int kp;
		int first;
		int second;
		logic [15:0] pair;
		kp = $urandom_range(0, 100);
		pair = '0;
		first = -1;
		second = -1;
		if (style == KEYS_LUCKY || style == KEYS_WIDE) begin
			pair = (style == KEYS_LUCKY) ? lucky_keys[$urandom_range(0, lucky_keys.size() - 1)]
				: wide_keys[$urandom_range(0, wide_keys.size() - 1)];
			first = $urandom_range(0, len - 2);
			second = $urandom_range(first + 1, len - 1);
		end
		for (int i = 0; i < len; i++) begin
			case (style)
				KEYS_NONE: put_byte(8'($urandom_range(0, 255)), 1'b0);
				KEYS_ALL: put_byte(8'($urandom_range(0, 255)), 1'b1);
				KEYS_LUCKY, KEYS_WIDE: begin
					if (i == first)
						put_byte(pair[7:0], 1'b1);
					else if (i == second)
						put_byte(pair[15:8], 1'b1);
					else
						put_byte(8'($urandom_range(0, 255)), 1'b0);
				end
				default: put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < kp);
			endcase
		end
	endtask

	task automatic settle();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		int hold;
		bit squeezed;
		hold = 0;
		squeezed = 1'b0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!squeezed && tracker.decisions_seen >= 18) begin
				squeezed = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				result_ch.ready = 1'b0;
				hold--;
			end else if (rx_calm || $urandom_range(0, 99) < 70) begin
				result_ch.ready = 1'b1;
			end else begin
				result_ch.ready = 1'b0;
				hold = pick_gap();
			end
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				tracker.match_decision(result_ch.starts_segment, result_ch.forced_by_limit);
		end
	end

	initial begin
		#(10_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [31:0] mixed;
		int len;
		int r;
		int target;
		key_style_t style;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.data_byte = '0;
		item_ch.key_byte = 1'b0;
		item_ch.element_end = 1'b0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		items_sent = 0;

		for (int v = 0; v < 65536; v++) begin
			mixed = tracker.avalanche(tracker.fold_byte(
				tracker.fold_byte(cdsc_pkg::HASH_BASIS, v[7:0]), v[15:8]));
			if (mixed < 32'h0040_0000)
				lucky_keys.push_back(v[15:0]);
			else if (mixed < LONG_LEN * 4096)
				wide_keys.push_back(v[15:0]);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset limits: the first element never cuts and the minimums block the hash.
		put_byte(8'h00, 1'b0);
		push_element();
		put_byte(8'hFF, 1'b1);
		push_element();
		put_byte(8'h00, 1'b1);
		put_byte(8'hFF, 1'b1);
		put_byte(8'h55, 1'b1);
		put_byte(8'hAA, 1'b1);
		push_element();
		put_byte(8'h5A, 1'b0);
		put_byte(8'hA5, 1'b0);
		put_byte(8'hFF, 1'b0);
		push_element();
		put_byte(8'h01, 1'b0);
		put_byte(8'h80, 1'b1);
		put_byte(8'h7F, 1'b0);
		put_byte(8'hFE, 1'b1);
		push_element();
		settle();

		// Minimums of one let the hash decide.
		load_limits(32'd1, 32'd1, 32'd65535, 32'hFFFF_FFFF);
		build_element(2, KEYS_LUCKY);
		push_element();
		build_element(4, KEYS_LUCKY);
		push_element();
		put_byte(8'h33, 1'b0);
		push_element();
		settle();

		// A zero maximum forces a cut on every element; zero minimums are harmless.
		load_limits(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
		repeat (3) begin
			put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			push_element();
		end
		settle();
		load_limits(32'd0, 32'd0, 32'd65535, 32'd0);
		repeat (2) begin
			put_byte(8'($urandom_range(0, 255)), 1'b0);
			push_element();
		end
		settle();
		reg_write(cdsc_pkg::REG_MAX_SIZE_BYTES, 32'hFFFF_FFFF);
		build_element(3, KEYS_LUCKY);
		push_element();
		settle();

		// One long element raises the byte-per-element threshold above its floor.
		load_limits(32'd1, 32'd1, 32'd65535, 32'hFFFF_FFFF);
		tx_calm = 1'b1;
		build_element(LONG_LEN, KEYS_LUCKY);
		push_element();
		if (wide_keys.size() != 0) begin
			build_element(3, KEYS_WIDE);
			push_element();
		end
		tx_calm = 1'b0;
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: load_limits(32'd1, 32'd1, 32'd65535, 32'hFFFF_FFFF);
				1: load_limits(32'd65535, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFFF);
				2: load_limits(32'd3, 32'd20, 32'd65535, 32'd40);
				3: load_limits($urandom_range(1, 8), $urandom_range(1, 64),
					$urandom_range(2, 12), $urandom_range(16, 80));
				4: load_limits(32'd64, 32'd65536, 32'd16384, 32'd16777216);
				default: load_limits($urandom, $urandom_range(1, 200), $urandom,
					$urandom_range(20, 300));
			endcase
			tx_calm = (ph == 2);
			rx_calm = (ph == 4);
			target = items_sent + 70;
			while (items_sent < target) begin
				len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 24);
				r = $urandom_range(0, 99);
				if (r < 15 && len >= 2 && lucky_keys.size() != 0)
					style = KEYS_LUCKY;
				else if (r < 25)
					style = KEYS_NONE;
				else if (r < 35)
					style = KEYS_ALL;
				else
					style = KEYS_RANDOM;
				build_element(len, style);
				push_element();
			end
			settle();
		end

		if (tracker.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
